// ----- hdl/tsq_pkg.sv -----
// shared constants and codes for the two-stack queue
`default_nettype none

package tsq_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 5;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 5;

  // capacity register value after reset
  localparam int CAP_RESET = 16;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

endpackage

`default_nettype wire

// ----- hdl/tsq_if.sv -----
// command and result channel interfaces of the two-stack queue
`default_nettype none

interface tsq_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                             valid;
  logic                             ready;
  logic [tsq_pkg::OP_W-1:0]         operation;
  logic signed [DATA_WIDTH-1:0]     value_in;
  logic [tsq_pkg::IDX_W-1:0]        index;

  modport source(output valid, operation, value_in, index, input ready);
  modport sink(input valid, operation, value_in, index, output ready);
endinterface

interface tsq_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                             valid;
  logic                             ready;
  logic signed [DATA_WIDTH-1:0]     value_out;
  logic [tsq_pkg::COUNT_W-1:0]      count;
  logic                             is_full;
  logic [tsq_pkg::STATUS_W-1:0]     status;

  modport source(output valid, value_out, count, is_full, status, input ready);
  modport sink(input valid, value_out, count, is_full, status, output ready);
endinterface

`default_nettype wire

// ----- hdl/two_stack_queue_core.sv -----
// fifo queue made of two bounded stacks with a one-element-per-cycle reload sequencer
// flow: push without reload and errors go straight to S_DONE; pop and read pass S_WAIT
//   for the memory read; a reload runs S_MOVE over the input stack before S_PUSH or S_POP
// one command at a time: the next is taken only after the result has left S_DONE,
//   which holds while out_chan has not yet taken the previous result
// reset: synchronous active-low rst_n empties both stacks and sets capacity to 16;
//   stack memories are not cleared, a capacity write also empties the queue
`default_nettype none

module two_stack_queue_core #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [tsq_pkg::CAP_W-1:0] cfg_wr_data,
  tsq_in_if.sink                         in_chan,
  tsq_out_if.source                      out_chan
);

  localparam int TOP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SUM_W   = TOP_W + 1;
  localparam int IW      = (SUM_W > tsq_pkg::IDX_W) ? SUM_W : tsq_pkg::IDX_W;
  localparam int CW      = (TOP_W > tsq_pkg::CAP_W) ? TOP_W : tsq_pkg::CAP_W;
  localparam int RST_CAP = (tsq_pkg::CAP_RESET > STACK_DEPTH) ? STACK_DEPTH
                                                               : tsq_pkg::CAP_RESET;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PUSH,
    S_POP,
    S_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_IN,
    SRC_OUT
  } src_t;

  state_t                         state_r;
  state_t                         after_r;
  src_t                           src_r;
  logic [TOP_W-1:0]               cap_r;
  logic [TOP_W-1:0]               in_top_r;
  logic [TOP_W-1:0]               out_top_r;
  logic [TOP_W-1:0]               mv_cnt_r;
  logic [TOP_W-1:0]               mv_n_r;
  logic [DATA_WIDTH-1:0]          val_r;
  logic [DATA_WIDTH-1:0]          res_r;
  logic [tsq_pkg::STATUS_W-1:0]   status_r;

  logic                           out_valid_r;
  logic [DATA_WIDTH-1:0]          out_value_r;
  logic [tsq_pkg::COUNT_W-1:0]    out_count_r;
  logic                           out_full_r;
  logic [tsq_pkg::STATUS_W-1:0]   out_status_r;

  logic [DATA_WIDTH-1:0]          in_mem  [STACK_DEPTH];
  logic [DATA_WIDTH-1:0]          out_mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0]          in_rdata_r;
  logic [DATA_WIDTH-1:0]          out_rdata_r;

  logic                           in_we;
  logic [ADDR_W-1:0]              in_waddr;
  logic [DATA_WIDTH-1:0]          in_wdata;
  logic [ADDR_W-1:0]              in_raddr;
  logic                           out_we;
  logic [ADDR_W-1:0]              out_waddr;
  logic [ADDR_W-1:0]              out_raddr;

  logic                           accept;
  logic                           emit;
  logic                           full;
  logic                           need_reload;
  logic [SUM_W-1:0]               total;
  logic [IW-1:0]                  idx_ext;
  logic [IW-1:0]                  total_ext;
  logic [IW-1:0]                  otop_ext;
  logic [CW-1:0]                  cfg_ext;
  logic [TOP_W-1:0]               cap_in;

  // a capacity write takes the cycle, no command beat alongside it
  assign in_chan.ready      = (state_r == S_IDLE) && !cfg_wr_en;
  assign accept             = in_chan.valid && in_chan.ready;
  assign emit               = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign out_chan.valid     = out_valid_r;
  assign out_chan.value_out = out_value_r;
  assign out_chan.count     = out_count_r;
  assign out_chan.is_full   = out_full_r;
  assign out_chan.status    = out_status_r;

  assign total       = SUM_W'(in_top_r) + SUM_W'(out_top_r);
  assign full        = (out_top_r != '0) && (in_top_r >= cap_r);
  assign need_reload = (in_top_r >= cap_r) && (out_top_r == '0);
  assign idx_ext     = IW'(in_chan.index);
  assign total_ext   = IW'(total);
  assign otop_ext    = IW'(out_top_r);

  // capacity clamped to 1..STACK_DEPTH when written
  assign cfg_ext = CW'(cfg_wr_data);
  always_comb begin
    if (cfg_ext == '0) begin
      cap_in = TOP_W'(1);
    end else if (cfg_ext > CW'(STACK_DEPTH)) begin
      cap_in = TOP_W'(STACK_DEPTH);
    end else begin
      cap_in = TOP_W'(cfg_ext);
    end
  end

  // memory port steering
  always_comb begin
    in_we     = 1'b0;
    in_waddr  = ADDR_W'(in_top_r);
    in_wdata  = val_r;
    if (state_r == S_PUSH) begin
      in_we = 1'b1;
    end else if (accept && in_chan.operation == tsq_pkg::OP_PUSH && !full && !need_reload) begin
      in_we    = 1'b1;
      in_wdata = in_chan.value_in;
    end

    // reload reads from the top of the input stack downward
    if (state_r == S_MOVE) begin
      in_raddr = ADDR_W'(mv_n_r - TOP_W'(1) - mv_cnt_r);
    end else begin
      in_raddr = ADDR_W'(idx_ext - otop_ext);
    end

    // the write uses the registered read data, so it trails the read into the next cycle
    out_we    = (state_r == S_MOVE) && (mv_cnt_r != '0);
    out_waddr = ADDR_W'(mv_cnt_r - TOP_W'(1));

    if (state_r == S_POP || in_chan.operation == tsq_pkg::OP_POP) begin
      out_raddr = ADDR_W'(out_top_r - TOP_W'(1));
    end else begin
      out_raddr = ADDR_W'(otop_ext - IW'(1) - idx_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[in_waddr] <= in_wdata;
    end
    in_rdata_r <= in_mem[in_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_waddr] <= in_rdata_r;
    end
    out_rdata_r <= out_mem[out_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_PUSH;
      cap_r       <= TOP_W'(RST_CAP);
      in_top_r    <= '0;
      out_top_r   <= '0;
      mv_cnt_r    <= '0;
      mv_n_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit && !cfg_wr_en) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        // capacity write empties the queue
        cap_r     <= cap_in;
        in_top_r  <= '0;
        out_top_r <= '0;
      end else begin
        case (state_r)
          S_IDLE: begin
            if (accept) begin
              status_r <= tsq_pkg::ST_OK;
              src_r    <= SRC_NONE;
              val_r    <= in_chan.value_in;
              res_r    <= '0;
              state_r  <= S_DONE;
              case (in_chan.operation)
                tsq_pkg::OP_PUSH: begin
                  if (full) begin
                    status_r <= tsq_pkg::ST_PUSH_FULL;
                  end else if (need_reload) begin
                    mv_cnt_r <= '0;
                    mv_n_r   <= in_top_r;
                    after_r  <= S_PUSH;
                    state_r  <= S_MOVE;
                  end else begin
                    in_top_r <= in_top_r + TOP_W'(1);
                  end
                end
                tsq_pkg::OP_POP: begin
                  if (total == '0) begin
                    status_r <= tsq_pkg::ST_POP_EMPTY;
                  end else if (out_top_r == '0) begin
                    mv_cnt_r <= '0;
                    mv_n_r   <= in_top_r;
                    after_r  <= S_POP;
                    state_r  <= S_MOVE;
                  end else begin
                    out_top_r <= out_top_r - TOP_W'(1);
                    src_r     <= SRC_OUT;
                    state_r   <= S_WAIT;
                  end
                end
                tsq_pkg::OP_READ: begin
                  if (idx_ext >= total_ext) begin
                    status_r <= tsq_pkg::ST_RANGE;
                  end else if (idx_ext < otop_ext) begin
                    src_r   <= SRC_OUT;
                    state_r <= S_WAIT;
                  end else begin
                    src_r   <= SRC_IN;
                    state_r <= S_WAIT;
                  end
                end
                default: begin
                  state_r <= S_DONE;
                end
              endcase
            end
          end
          S_MOVE: begin
            if (mv_cnt_r == mv_n_r) begin
              out_top_r <= mv_n_r;
              in_top_r  <= '0;
              state_r   <= after_r;
            end else begin
              mv_cnt_r <= mv_cnt_r + TOP_W'(1);
            end
          end
          S_PUSH: begin
            in_top_r <= in_top_r + TOP_W'(1);
            state_r  <= S_DONE;
          end
          S_POP: begin
            out_top_r <= out_top_r - TOP_W'(1);
            src_r     <= SRC_OUT;
            state_r   <= S_WAIT;
          end
          S_WAIT: begin
            case (src_r)
              SRC_IN:  res_r <= in_rdata_r;
              SRC_OUT: res_r <= out_rdata_r;
              default: res_r <= '0;
            endcase
            state_r <= S_DONE;
          end
          S_DONE: begin
            if (emit) begin
              out_value_r  <= res_r;
              out_count_r  <= tsq_pkg::COUNT_W'(total);
              out_full_r   <= full;
              out_status_r <= status_r;
              state_r      <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_in_top_cap: assert property (@(posedge clk) disable iff (!rst_n)
    in_top_r <= cap_r)
    else $error("input stack above capacity");

  a_out_top_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_top_r <= TOP_W'(STACK_DEPTH))
    else $error("output stack above depth");

  a_move_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> mv_cnt_r <= mv_n_r)
    else $error("reload counter overran");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == tsq_pkg::ST_POP_EMPTY) |-> out_count_r == '0)
    else $error("pop on empty reported nonzero count");
`endif

endmodule

`default_nettype wire

// ----- dv/two_stack_queue_core_tb.sv -----
// testbench for two_stack_queue_core: random push/pop/read traffic checked against a predictor
`timescale 1ns / 100ps

typedef struct {
  logic signed [31:0]             value_out;
  logic [tsq_pkg::COUNT_W-1:0]    count;
  logic                           is_full;
  logic [tsq_pkg::STATUS_W-1:0]   status;
} queue_result_t;

class queue_scoreboard;
  logic [31:0]               in_stk[16];
  logic [31:0]               out_stk[16];
  int                        in_top;
  int                        out_top;
  logic [tsq_pkg::CAP_W-1:0] capacity;
  queue_result_t             expected_results[$];
  int                        mismatch_count;

  function void reset_state();
    in_top = 0;
    out_top = 0;
    capacity = tsq_pkg::CAP_W'(tsq_pkg::CAP_RESET);
    expected_results.delete();
    mismatch_count = 0;
  endfunction

  function void set_capacity(logic [tsq_pkg::CAP_W-1:0] cap);
    capacity = cap;
    in_top = 0;
    out_top = 0;
  endfunction

  function int depth_limit();
    if (capacity < 1) return 1;
    if (capacity > 16) return 16;
    return int'(capacity);
  endfunction

  function bit is_full();
    return out_top != 0 && in_top >= depth_limit();
  endfunction

  function int queue_count();
    return in_top + out_top;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // move the input stack, reversed, onto the empty output stack
  function void reload();
    for (int i = 0; i < in_top; i++) out_stk[i] = in_stk[in_top - 1 - i];
    out_top = in_top;
    in_top = 0;
  endfunction

  function void note_command(logic [tsq_pkg::OP_W-1:0] op, logic [31:0] val,
                             logic [tsq_pkg::IDX_W-1:0] idx);
    queue_result_t r;
    int cap;
    int total;
    cap = depth_limit();
    total = in_top + out_top;
    r.value_out = '0;
    r.status = tsq_pkg::ST_OK;
    case (op)
      tsq_pkg::OP_PUSH: begin
        if (is_full()) begin
          r.status = tsq_pkg::ST_PUSH_FULL;
        end else begin
          if (in_top >= cap && out_top == 0) reload();
          if (in_top < cap) begin
            in_stk[in_top] = val;
            in_top++;
          end
        end
      end
      tsq_pkg::OP_POP: begin
        if (total == 0) begin
          r.status = tsq_pkg::ST_POP_EMPTY;
        end else begin
          if (out_top == 0) reload();
          out_top--;
          r.value_out = out_stk[out_top];
        end
      end
      tsq_pkg::OP_READ: begin
        if (idx >= total) r.status = tsq_pkg::ST_RANGE;
        else if (idx < out_top) r.value_out = out_stk[out_top - 1 - idx];
        else r.value_out = in_stk[idx - out_top];
      end
      default: ;
    endcase
    r.count = tsq_pkg::COUNT_W'(in_top + out_top);
    r.is_full = is_full();
    expected_results.push_back(r);
  endfunction

  function void check_result(queue_result_t got);
    queue_result_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: result beat with nothing expected: value %h count %0d full %0b status %0d",
               $time, got.value_out, got.count, got.is_full, got.status);
      mismatch_count++;
      return;
    end
    exp_r = expected_results.pop_front();
    if (got.value_out !== exp_r.value_out) begin
      $display("%0t: value_out expected %h actual %h", $time, exp_r.value_out, got.value_out);
      mismatch_count++;
    end
    if (got.count !== exp_r.count) begin
      $display("%0t: count expected %0d actual %0d", $time, exp_r.count, got.count);
      mismatch_count++;
    end
    if (got.is_full !== exp_r.is_full) begin
      $display("%0t: is_full expected %0b actual %0b", $time, exp_r.is_full, got.is_full);
      mismatch_count++;
    end
    if (got.status !== exp_r.status) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
      mismatch_count++;
    end
  endfunction
endclass

module two_stack_queue_core_tb;

  localparam logic [tsq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 140;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [tsq_pkg::CAP_W-1:0] cfg_wr_data;

  bit no_idle;
  bit hold_request;
  int stall_left;

  queue_scoreboard sb;

  tsq_in_if  #(.DATA_WIDTH(32)) in_if ();
  tsq_out_if #(.DATA_WIDTH(32)) out_if ();

  two_stack_queue_core #(
    .STACK_DEPTH(16),
    .DATA_WIDTH (32)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_chan    (in_if),
    .out_chan   (out_if)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    #20_000_000;
    $display("two_stack_queue_core_tb failed");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    case (r % 8)
      0: if (r < 16) return 32'h7fff_ffff;
      1: if (r < 16) return 32'h8000_0000;
      2: if (r < 16) return 32'h0000_0000;
      3: if (r < 16) return 32'hffff_ffff;
      default: ;
    endcase
    return $urandom;
  endfunction

  // called at a falling edge; returns at the falling edge after the accepting beat
  task automatic send_command(logic [tsq_pkg::OP_W-1:0] op, logic [31:0] val,
                              logic [tsq_pkg::IDX_W-1:0] idx);
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.value_in  <= val;
    in_if.index     <= idx;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(op, val, idx);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (!no_idle && $urandom_range(0, 99) < 30) n = pick_gap();
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [tsq_pkg::CAP_W-1:0] cap);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    sb.set_capacity(cap);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_command(int push_pct);
    int r;
    int cnt;
    logic [tsq_pkg::IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    cnt = sb.queue_count();
    idx = tsq_pkg::IDX_W'($urandom_range(0, 31));
    if (cnt > 0 && $urandom_range(0, 99) < 70) idx = tsq_pkg::IDX_W'($urandom_range(0, cnt - 1));
    if (r < 2) send_command(OP_UNUSED, pick_value(), idx);
    else if (r < push_pct) send_command(tsq_pkg::OP_PUSH, pick_value(), idx);
    else if (r < push_pct + (100 - push_pct) * 6 / 10) begin
      send_command(tsq_pkg::OP_POP, pick_value(), idx);
    end
    else send_command(tsq_pkg::OP_READ, pick_value(), idx);
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.value_out = out_if.value_out;
      got.count     = out_if.count;
      got.is_full   = out_if.is_full;
      got.status    = out_if.status;
      sb.check_result(got);
    end
  end

  initial begin
    logic [tsq_pkg::CAP_W-1:0] caps[10];
    int push_pcts[10];
    sb = new();
    sb.reset_state();
    no_idle = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_if.valid = 1'b0;
    in_if.operation = tsq_pkg::OP_PUSH;
    in_if.value_in = '0;
    in_if.index = '0;
    caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16, 5'd3, 5'd0};
    caps[9] = tsq_pkg::CAP_W'($urandom_range(0, 31));
    push_pcts = '{65, 55, 50, 70, 45, 60, 40, 75, 55, 50};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty queue errors, unused code, data extremes, reads at both ends
    send_command(tsq_pkg::OP_POP, 32'h0, 5'd0);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd0);
    send_command(OP_UNUSED, 32'hdead_beef, 5'd31);
    send_command(tsq_pkg::OP_PUSH, 32'h7fff_ffff, 5'd0);
    send_command(tsq_pkg::OP_PUSH, 32'h8000_0000, 5'd31);
    send_command(tsq_pkg::OP_PUSH, 32'h0000_0000, 5'd0);
    send_command(tsq_pkg::OP_PUSH, 32'hffff_ffff, 5'd0);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd0);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd3);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd4);
    send_command(tsq_pkg::OP_READ, 32'hffff_ffff, 5'd31);
    send_command(tsq_pkg::OP_POP, 32'h0, 5'd0);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd0);

    // capacity one: reload on the second push, then push when full
    write_capacity(5'd1);
    send_command(tsq_pkg::OP_PUSH, 32'h1111_1111, 5'd0);
    send_command(tsq_pkg::OP_PUSH, 32'h2222_2222, 5'd0);
    send_command(tsq_pkg::OP_PUSH, 32'h3333_3333, 5'd0);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd0);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd1);
    send_command(tsq_pkg::OP_READ, 32'h0, 5'd2);
    send_command(tsq_pkg::OP_POP, 32'h0, 5'd0);
    send_command(tsq_pkg::OP_POP, 32'h0, 5'd0);
    send_command(tsq_pkg::OP_POP, 32'h0, 5'd0);

    for (int ph = 0; ph < 10; ph++) begin
      write_capacity(caps[ph]);
      no_idle = (ph == 3 || ph == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result-side hold-off while commands keep coming
        if (ph == 1 && i == 20) hold_request = 1'b1;
        if (ph == 5 && i == PHASE_ITEMS / 2) wait_drained();
        random_command(push_pcts[ph]);
        sender_gap();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (40) @(negedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("two_stack_queue_core_tb passed");
    end else begin
      $display("two_stack_queue_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tsq_pkg.sv
hdl/tsq_if.sv
hdl/two_stack_queue_core.sv
dv/two_stack_queue_core_tb.sv
